// ----- rtl/tkbt_pkg.sv -----
package tkbt_pkg;

    localparam int CHANNELS = 16;
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHAN_W   = 4;
    localparam int SAMPLE_W = 16;
    localparam int KEYS_W   = 16;
    localparam int CNT_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_DIFF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEB_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_FRAMES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_DELAY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_DELAY  = 3'd4;

    localparam logic [SAMPLE_W-1:0] TOUCH_DIFF_RST = 16'd5000;
    localparam logic [CNT_W-1:0]    DEB_LIMIT_RST  = 8'd3;
    localparam logic [CNT_W-1:0]    CAL_FRAMES_RST = 8'd20;
    localparam logic [CNT_W-1:0]    RISE_DELAY_RST = 8'd20;
    localparam logic [CNT_W-1:0]    FALL_DELAY_RST = 8'd100;
    localparam logic [CNT_W-1:0]    CNT_MAX        = 8'hFF;

    typedef struct packed {
        logic [SAMPLE_W-1:0] touch_diff;
        logic [CNT_W-1:0]    deb_limit;
        logic [CNT_W-1:0]    cal_frames;
        logic [CNT_W-1:0]    rise_delay;
        logic [CNT_W-1:0]    fall_delay;
    } tkbt_cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] baseline;
        logic [CNT_W-1:0]    rise_cnt;
        logic [CNT_W-1:0]    fall_cnt;
        logic [CNT_W-1:0]    deb_cnt;
    } track_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FLUSH,
        ST_REPORT
    } tkbt_state_t;

endpackage

// ----- rtl/tkbt_ifs.sv -----
interface tkbt_conv_if import tkbt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink (input valid, input channel, input sample, output ready);
endinterface

interface tkbt_result_if import tkbt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KEYS_W-1:0] key_states;
    logic              calibrated;
    logic              frame_done;

    modport source (output valid, output key_states, output calibrated, output frame_done,
                    input ready);
    modport sink (input valid, input key_states, input calibrated, input frame_done,
                  output ready);
endinterface

// ----- rtl/tkbt_chan_update.sv -----
module tkbt_chan_update import tkbt_pkg::*;
(
    input  tkbt_cfg_t           cfg,
    input  logic [SAMPLE_W-1:0] count,
    input  track_entry_t        cur,
    input  logic                pressed,
    output track_entry_t        nxt,
    output logic                pressed_nxt
);

    logic [SAMPLE_W-1:0] thr;
    logic [CNT_W-1:0]    deb_up;

    always_comb
    begin
        thr = (cur.baseline > cfg.touch_diff) ? (cur.baseline - cfg.touch_diff) : '0;
        deb_up = (cur.deb_cnt < CNT_MAX) ? (cur.deb_cnt + 8'd1) : cur.deb_cnt;
        nxt = cur;
        pressed_nxt = pressed;
        if (count > cur.baseline)
        begin
            nxt.fall_cnt = '0;
            if (cur.rise_cnt < cfg.rise_delay)
            begin
                nxt.rise_cnt = cur.rise_cnt + 8'd1;
            end
            else
            begin
                nxt.baseline = cur.baseline + 16'd1;
            end
        end
        else if (count < thr)
        begin
            nxt.rise_cnt = '0;
            nxt.fall_cnt = '0;
            nxt.deb_cnt = deb_up;
            if (deb_up > cfg.deb_limit)
            begin
                pressed_nxt = 1'b1;
            end
        end
        else
        begin
            nxt.rise_cnt = '0;
            if (cur.fall_cnt < cfg.fall_delay)
            begin
                nxt.fall_cnt = cur.fall_cnt + 8'd1;
            end
            else if (count < cur.baseline)
            begin
                nxt.baseline = cur.baseline - 16'd1;
            end
        end
        if (!(count < thr) || (count > cur.baseline))
        begin
            if (cur.deb_cnt != '0)
            begin
                nxt.deb_cnt = cur.deb_cnt - 8'd1;
            end
            else
            begin
                pressed_nxt = 1'b0;
            end
        end
    end

endmodule

// ----- rtl/touch_key_baseline_tracker_top.sv -----
// Touch key baseline tracker.
// Each item on the conv channel is one finished conversion: a channel number and
// its raw count. Every accepted item yields exactly one item on the result
// channel, carrying the debounced key bitmap, the calibrated flag and frame_done.
// An item that does not finish a frame is answered from the output register in
// the cycle after it is accepted, so such items can be taken every cycle while
// the result receiver is ready. An item on the last channel finishes a frame. If
// that frame captures baselines or tracks them, the block walks all channels
// through the per-channel memories, one channel per cycle with registered reads,
// then passes ST_FLUSH and ST_REPORT, where the result is loaded into the output
// register; conv.ready stays low until the block is idle again. Configuration
// registers are written through cfg_we, cfg_index and cfg_data while the block
// is idle (the user's rule; not enforced). Writes to unknown indexes are ignored.
// After reset the registers hold their default values, no key is pressed, and
// the block waits for calibration frames. If the result receiver stalls, one
// finished result waits in the output register and no new item is accepted.
module touch_key_baseline_tracker_top import tkbt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    tkbt_conv_if.sink             conv,
    tkbt_result_if.source         result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    tkbt_cfg_t           cfg_reg;
    tkbt_state_t         state_reg;
    tkbt_state_t         state_next;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [IDX_W-1:0]    wr_idx_reg;
    logic                pend_reg;
    logic                capture_reg;
    logic [CNT_W-1:0]    frame_cnt_reg;
    logic                baseline_ready_reg;
    logic [CHANNELS-1:0] pressed_reg;

    logic [SAMPLE_W-1:0] latest_mem [CHANNELS];
    track_entry_t        track_mem [CHANNELS];
    logic [SAMPLE_W-1:0] latest_rdata_reg;
    track_entry_t        track_rdata_reg;

    logic                out_valid_reg;
    logic [KEYS_W-1:0]   out_keys_reg;
    logic                out_cal_reg;
    logic                out_done_reg;

    logic                accept;
    logic                in_range;
    logic                frame_end;
    logic [CNT_W-1:0]    frame_cnt_inc;
    logic                do_capture;
    logic                do_sweep;
    logic                load_now;
    logic                load_report;
    logic                sweep_last;
    track_entry_t        upd_entry;
    logic                upd_pressed;
    track_entry_t        wr_entry;

    assign in_range = ({1'b0, conv.channel} < (CHAN_W + 1)'(CHANNELS));
    assign accept = conv.valid && conv.ready;
    assign frame_end = in_range && (conv.channel == CHAN_W'(CHANNELS - 1));
    assign frame_cnt_inc = (frame_cnt_reg == CNT_MAX) ? frame_cnt_reg
                                                      : frame_cnt_reg + 8'd1;
    assign do_capture = !baseline_ready_reg && (frame_cnt_inc > cfg_reg.cal_frames);
    assign do_sweep = frame_end && (do_capture || baseline_ready_reg);
    assign sweep_last = (rd_idx_reg == IDX_W'(CHANNELS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && do_sweep)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:  state_next = ST_REPORT;
            ST_REPORT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        conv.ready = 1'b0;
        load_report = 1'b0;
        case (state_reg)
            ST_IDLE:   conv.ready = !out_valid_reg || result.ready;
            ST_REPORT: load_report = 1'b1;
            default:
            begin
                conv.ready = 1'b0;
            end
        endcase
        load_now = accept && !do_sweep;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.touch_diff <= TOUCH_DIFF_RST;
            cfg_reg.deb_limit  <= DEB_LIMIT_RST;
            cfg_reg.cal_frames <= CAL_FRAMES_RST;
            cfg_reg.rise_delay <= RISE_DELAY_RST;
            cfg_reg.fall_delay <= FALL_DELAY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TOUCH_DIFF: cfg_reg.touch_diff <= cfg_data;
                CFG_DEB_LIMIT:  cfg_reg.deb_limit  <= cfg_data[CNT_W-1:0];
                CFG_CAL_FRAMES: cfg_reg.cal_frames <= cfg_data[CNT_W-1:0];
                CFG_RISE_DELAY: cfg_reg.rise_delay <= cfg_data[CNT_W-1:0];
                CFG_FALL_DELAY: cfg_reg.fall_delay <= cfg_data[CNT_W-1:0];
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rd_idx_reg <= '0;
            pend_reg <= 1'b0;
            capture_reg <= 1'b0;
            frame_cnt_reg <= '0;
            baseline_ready_reg <= 1'b0;
            pressed_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg <= (state_reg == ST_SWEEP);
            if (state_reg == ST_SWEEP && !sweep_last)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            else
            begin
                rd_idx_reg <= '0;
            end
            if (accept && frame_end)
            begin
                frame_cnt_reg <= frame_cnt_inc;
                capture_reg <= do_capture;
                if (do_capture)
                begin
                    baseline_ready_reg <= 1'b1;
                end
            end
            if (pend_reg && !capture_reg)
            begin
                pressed_reg[wr_idx_reg] <= upd_pressed;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_idx_reg <= rd_idx_reg;
        latest_rdata_reg <= latest_mem[rd_idx_reg];
        track_rdata_reg <= track_mem[rd_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_range)
        begin
            latest_mem[conv.channel[IDX_W-1:0]] <= conv.sample;
        end
    end

    tkbt_chan_update u_update (
        .cfg         (cfg_reg),
        .count       (latest_rdata_reg),
        .cur         (track_rdata_reg),
        .pressed     (pressed_reg[wr_idx_reg]),
        .nxt         (upd_entry),
        .pressed_nxt (upd_pressed)
    );

    always_comb
    begin
        if (capture_reg)
        begin
            wr_entry = '{baseline: latest_rdata_reg, rise_cnt: '0, fall_cnt: '0, deb_cnt: '0};
        end
        else
        begin
            wr_entry = upd_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            track_mem[wr_idx_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_now || load_report)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_now || load_report)
        begin
            out_keys_reg <= KEYS_W'(pressed_reg);
            out_cal_reg <= baseline_ready_reg;
            out_done_reg <= load_report || (accept && frame_end);
        end
    end

    assign result.valid = out_valid_reg;
    assign result.key_states = out_keys_reg;
    assign result.calibrated = out_cal_reg;
    assign result.frame_done = out_done_reg;

    a_report_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_REPORT |-> !out_valid_reg)
        else $error("Output register is occupied when a frame result is ready.");

    a_sweep_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && do_sweep |=> state_reg == ST_SWEEP && rd_idx_reg == '0)
        else $error("Frame walk did not start at the first channel.");

    a_calibration_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        baseline_ready_reg |=> baseline_ready_reg)
        else $error("Calibrated flag was cleared.");

    a_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWEEP |=> pend_reg && wr_idx_reg == $past(rd_idx_reg))
        else $error("Write-back is not aligned with the memory read.");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

import tkbt_pkg::*;

typedef struct packed {
    logic [KEYS_W-1:0] key_states;
    logic              calibrated;
    logic              frame_done;
} key_report_t;

class touch_scoreboard;
    logic [SAMPLE_W-1:0] touch_diff;
    logic [CNT_W-1:0]    deb_limit;
    logic [CNT_W-1:0]    cal_frames;
    logic [CNT_W-1:0]    rise_delay;
    logic [CNT_W-1:0]    fall_delay;

    logic [SAMPLE_W-1:0] counts[CHANNELS];
    logic [SAMPLE_W-1:0] baselines[CHANNELS];
    logic [CNT_W-1:0]    rise_cnt[CHANNELS];
    logic [CNT_W-1:0]    fall_cnt[CHANNELS];
    logic [CNT_W-1:0]    deb_cnt[CHANNELS];
    logic                pressed[CHANNELS];
    logic [CNT_W-1:0]    frames;
    logic                baseline_ready;

    key_report_t pending_reports[$];
    int          errors;

    function new();
        touch_diff     = TOUCH_DIFF_RST;
        deb_limit      = DEB_LIMIT_RST;
        cal_frames     = CAL_FRAMES_RST;
        rise_delay     = RISE_DELAY_RST;
        fall_delay     = FALL_DELAY_RST;
        frames         = '0;
        baseline_ready = 1'b0;
        errors         = 0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            counts[c]    = '0;
            baselines[c] = '0;
            rise_cnt[c]  = '0;
            fall_cnt[c]  = '0;
            deb_cnt[c]   = '0;
            pressed[c]   = 1'b0;
        end
    endfunction

    function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_TOUCH_DIFF: touch_diff = data[SAMPLE_W-1:0];
            CFG_DEB_LIMIT:  deb_limit  = data[CNT_W-1:0];
            CFG_CAL_FRAMES: cal_frames = data[CNT_W-1:0];
            CFG_RISE_DELAY: rise_delay = data[CNT_W-1:0];
            CFG_FALL_DELAY: fall_delay = data[CNT_W-1:0];
            default: ;
        endcase
    endfunction

    function void release_step(int c);
        if (deb_cnt[c] > 0)
            deb_cnt[c]--;
        else
            pressed[c] = 1'b0;
    endfunction

    function void track_key(int c);
        logic [SAMPLE_W-1:0] cnt;
        logic [SAMPLE_W-1:0] base;
        logic [SAMPLE_W-1:0] thr;
        cnt  = counts[c];
        base = baselines[c];
        thr  = (base > touch_diff) ? base - touch_diff : '0;
        if (cnt > base)
        begin
            fall_cnt[c] = '0;
            if (rise_cnt[c] < rise_delay)
                rise_cnt[c]++;
            else
                baselines[c] = base + 1'b1;
            release_step(c);
        end
        else if (cnt < thr)
        begin
            rise_cnt[c] = '0;
            fall_cnt[c] = '0;
            if (deb_cnt[c] != CNT_MAX)
                deb_cnt[c]++;
            if (deb_cnt[c] > deb_limit)
                pressed[c] = 1'b1;
        end
        else
        begin
            rise_cnt[c] = '0;
            if (fall_cnt[c] < fall_delay)
                fall_cnt[c]++;
            else if (cnt < base)
                baselines[c] = base - 1'b1;
            release_step(c);
        end
    endfunction

    function void note_conversion(logic [CHAN_W-1:0] ch, logic [SAMPLE_W-1:0] smp);
        key_report_t rpt;
        rpt = '0;
        if (int'(ch) < CHANNELS)
        begin
            counts[ch] = smp;
            if (int'(ch) == CHANNELS - 1)
            begin
                rpt.frame_done = 1'b1;
                if (frames != CNT_MAX)
                    frames++;
                if (!baseline_ready)
                begin
                    if (frames > cal_frames)
                    begin
                        baseline_ready = 1'b1;
                        for (int c = 0; c < CHANNELS; c++)
                            baselines[c] = counts[c];
                    end
                end
                else
                begin
                    for (int c = 0; c < CHANNELS; c++)
                        track_key(c);
                end
            end
        end
        for (int c = 0; c < CHANNELS; c++)
            rpt.key_states[c] = pressed[c];
        rpt.calibrated = baseline_ready;
        pending_reports.push_back(rpt);
    endfunction

    function void check_report(logic [KEYS_W-1:0] keys, logic cal, logic done);
        key_report_t exp_rpt;
        if (pending_reports.size() == 0)
        begin
            $error("report item arrived with no conversion outstanding");
            errors++;
            return;
        end
        exp_rpt = pending_reports.pop_front();
        if (keys !== exp_rpt.key_states)
        begin
            $error("key_states: expected %h, got %h", exp_rpt.key_states, keys);
            errors++;
        end
        if (cal !== exp_rpt.calibrated)
        begin
            $error("calibrated: expected %b, got %b", exp_rpt.calibrated, cal);
            errors++;
        end
        if (done !== exp_rpt.frame_done)
        begin
            $error("frame_done: expected %b, got %b", exp_rpt.frame_done, done);
            errors++;
        end
    endfunction
endclass

module tb;

    localparam int CLK_HALF     = 5;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 25;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 130;

    typedef enum logic [1:0] {
        LVL_ABOVE,
        LVL_TOUCH,
        LVL_BAND,
        LVL_RANDOM
    } level_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tkbt_conv_if   conv_bus ();
    tkbt_result_if report_bus ();

    touch_scoreboard sb;
    level_t          levels[CHANNELS];
    int              sender_burst;
    int              receiver_burst = 0;
    int unsigned     cycles = 0;

    touch_key_baseline_tracker_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .conv      (conv_bus),
        .result    (report_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The result is checked before the new conversion is noted, since a result
    // can never belong to an item accepted at the same edge.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (report_bus.valid && report_bus.ready)
                sb.check_report(report_bus.key_states, report_bus.calibrated,
                                report_bus.frame_done);
            if (conv_bus.valid && conv_bus.ready)
                sb.note_conversion(conv_bus.channel, conv_bus.sample);
            if (cfg_we)
                sb.apply_register(cfg_index, cfg_data);
        end
    end

    function automatic int draw_gap(ref int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
            burst = $urandom_range(10, 40);
        return $urandom_range(0, 18);
    endfunction

    function automatic level_t pick_level();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return LVL_ABOVE;
        if (r < 6)
            return LVL_TOUCH;
        if (r < 9)
            return LVL_BAND;
        return LVL_RANDOM;
    endfunction

    function automatic logic [SAMPLE_W-1:0] level_sample(input int c);
        logic [SAMPLE_W-1:0] base;
        logic [SAMPLE_W-1:0] thr;
        int                  span;
        base = sb.baselines[c];
        thr  = (base > sb.touch_diff) ? base - sb.touch_diff : '0;
        span = 65535 - int'(base);
        if (span > 300)
            span = 300;
        case (levels[c])
            LVL_ABOVE:
                if (span > 0)
                    return base + SAMPLE_W'($urandom_range(1, span));
            LVL_TOUCH:
                if (thr != 0)
                    return SAMPLE_W'($urandom_range(0, int'(thr) - 1));
            LVL_BAND:
                return SAMPLE_W'($urandom_range(int'(thr), int'(base)));
            default: ;
        endcase
        return SAMPLE_W'($urandom);
    endfunction

    task automatic send_conversion(input int c, input logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = draw_gap(sender_burst);
        if (gap > 0)
        begin
            conv_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        conv_bus.valid   <= 1'b1;
        conv_bus.channel <= CHAN_W'(c);
        conv_bus.sample  <= smp;
        @(posedge clk);
        while (!conv_bus.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        conv_bus.valid <= 1'b0;
        while (sb.pending_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic configure(input int phase);
        logic [SAMPLE_W-1:0] td;
        logic [CNT_W-1:0]    dl;
        logic [CNT_W-1:0]    cf;
        logic [CNT_W-1:0]    rd;
        logic [CNT_W-1:0]    fd;
        int                  i;
        if (phase == 1)
        begin
            td = '0;
            dl = '0;
            cf = '0;
            rd = '0;
            fd = '0;
        end
        else if (phase == PHASES - 1)
        begin
            td = 16'hFFFF;
            dl = 8'd254;
            cf = 8'd254;
            rd = 8'd255;
            fd = 8'd255;
        end
        else
        begin
            td = SAMPLE_W'($urandom_range(200, 6000));
            dl = CNT_W'($urandom_range(0, 6));
            cf = CNT_W'($urandom_range(0, 254));
            rd = CNT_W'($urandom_range(0, 12));
            fd = CNT_W'($urandom_range(0, 25));
        end
        write_register(CFG_TOUCH_DIFF, CFG_DATA_W'(td));
        write_register(CFG_DEB_LIMIT, CFG_DATA_W'(dl));
        write_register(CFG_CAL_FRAMES, CFG_DATA_W'(cf));
        write_register(CFG_RISE_DELAY, CFG_DATA_W'(rd));
        write_register(CFG_FALL_DELAY, CFG_DATA_W'(fd));
        for (i = int'(CFG_FALL_DELAY) + 1; i < (1 << CFG_IDX_W); i++)
            write_register(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    endtask

    task automatic run_directed();
        int c;
        send_conversion(0, 16'h0000);
        send_conversion(1, 16'hFFFF);
        send_conversion(2, 16'h5555);
        send_conversion(3, 16'hAAAA);
        for (c = 4; c < CHANNELS - 1; c++)
            send_conversion(c, SAMPLE_W'($urandom_range(8000, 60000)));
        send_conversion(CHANNELS - 1, 16'h8000);
        send_conversion(CHANNELS - 1, 16'h0000);
        send_conversion(CHANNELS - 1, 16'hFFFF);
        send_conversion(7, 16'h0001);
        send_conversion(CHANNELS - 1, 16'hFFFE);
    endtask

    // The frame counter has to run up to its ceiling before the baselines are
    // captured, so most items here close a frame.
    task automatic calibrate();
        int                  c;
        logic [SAMPLE_W-1:0] smp;
        while (!sb.baseline_ready)
        begin
            if ($urandom_range(0, 9) < 7)
                c = CHANNELS - 1;
            else
                c = $urandom_range(0, CHANNELS - 2);
            if (c != 0 && $urandom_range(0, 9) == 0)
                smp = SAMPLE_W'($urandom);
            else
                smp = SAMPLE_W'($urandom_range(8000, 60000));
            send_conversion(c, smp);
        end
        for (c = 0; c < CHANNELS; c++)
            levels[c] = pick_level();
        levels[0] = LVL_TOUCH;
    endtask

    // Channel 0 is held in touch so that its debounce counter reaches its ceiling.
    task automatic run_tracking(input int quota);
        int sent;
        int k;
        int c;
        sent = 0;
        for (c = 0; c < CHANNELS - 1; c++)
        begin
            send_conversion(c, level_sample(c));
            sent++;
        end
        while (sent < quota)
        begin
            k = $urandom_range(0, 2);
            repeat (k)
            begin
                c = $urandom_range(0, CHANNELS - 2);
                if (c != 0 && $urandom_range(0, 19) == 0)
                    levels[c] = pick_level();
                send_conversion(c, level_sample(c));
                sent++;
            end
            if ($urandom_range(0, 19) == 0)
                levels[CHANNELS - 1] = pick_level();
            send_conversion(CHANNELS - 1, level_sample(CHANNELS - 1));
            sent++;
        end
    endtask

    initial
    begin
        int gap;
        report_bus.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = draw_gap(receiver_burst);
            if (gap > 0)
            begin
                report_bus.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            report_bus.ready <= 1'b1;
            @(posedge clk);
            while (!report_bus.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        int phase;
        sb               = new();
        sender_burst     = 0;
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_TOUCH_DIFF;
        cfg_data         = '0;
        conv_bus.valid   = 1'b0;
        conv_bus.channel = '0;
        conv_bus.sample  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_register(CFG_CAL_FRAMES, 16'd254);
        run_directed();
        calibrate();
        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain();
                configure(phase);
            end
            run_tracking(PHASE_ITEMS);
        end
        drain();

        if (sb.errors == 0 && sb.pending_reports.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
